/* rtl/core/tlrq_pkg.sv */
`default_nettype none
package tlrq_pkg;
    localparam int DEF_TABLE_DEPTH = 16;
    localparam int DEF_PID_BITS = 16;
    localparam logic [7:0] AGE_MAX = 8'hFF;
    localparam logic [7:0] STARVING_AGE_RESET = 8'd5;

    localparam logic [2:0] OP_ENQUEUE = 3'd0;
    localparam logic [2:0] OP_SELECT = 3'd1;
    localparam logic [2:0] OP_PROMOTE = 3'd2;
    localparam logic [2:0] OP_EXITED = 3'd3;
    localparam logic [2:0] OP_KILL = 3'd4;
    localparam logic [2:0] OP_REAP = 3'd5;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    // Table selectors: one shared RAM holds all three tables.
    localparam logic [1:0] TB_HIGH = 2'd0;
    localparam logic [1:0] TB_NORMAL = 2'd1;
    localparam logic [1:0] TB_DEFUNCT = 2'd2;
endpackage
`default_nettype wire

/* rtl/core/tlrq_ram.sv */
`default_nettype none
module tlrq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input wire logic clk,
    input wire logic we,
    input wire logic [$clog2(DEPTH)-1:0] waddr,
    input wire logic [WIDTH-1:0] wdata,
    input wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Single write port, registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

/* rtl/core/two_level_ready_queue_scheduler.sv */
`default_nettype none
// Three FIFO tables (high ready, normal ready, defunct) live in one RAM and are
// worked on by a sequencer that moves one word per step. Enqueue, exited, a
// select on empty tables and the unused opcodes go straight to the output
// state. A search reads the table one entry at a time and closing the gap
// reads and rewrites each entry shifted; a kill searches both ready tables.
// Promote ages each normal entry and moves a starving one when high has room.
// The single RAM port pair sets the pace. in_ready is low while a transaction
// is in progress; a result waits in S_OUT until the output register is free,
// and the next transaction can be taken while that register still holds it.
module two_level_ready_queue_scheduler #(
    parameter int TABLE_DEPTH = tlrq_pkg::DEF_TABLE_DEPTH,
    parameter int PID_BITS = tlrq_pkg::DEF_PID_BITS
) (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic cfg_we,
    input wire logic [7:0] cfg_wdata,
    input wire logic in_valid,
    output logic in_ready,
    input wire logic [2:0] opcode,
    input wire logic [PID_BITS-1:0] pid,
    input wire logic is_high,
    input wire logic crit_flag,
    input wire logic [7:0] term_code,
    output logic out_valid,
    input wire logic out_ready,
    output logic [1:0] status,
    output logic [PID_BITS-1:0] out_pid,
    output logic out_high,
    output logic out_critical,
    output logic [7:0] out_term_code,
    output logic [$clog2(TABLE_DEPTH + 1)-1:0] high_count,
    output logic [$clog2(TABLE_DEPTH + 1)-1:0] normal_count,
    output logic [$clog2(TABLE_DEPTH + 1)-1:0] defunct_count
);
    import tlrq_pkg::*;

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int DW = PID_BITS + 8;
    localparam int AW = IW + 2;
    localparam logic [CW-1:0] FULLC = CW'(TABLE_DEPTH);

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_RD = 9'b000000010,
        S_CHK = 9'b000000100,
        S_SH_RD = 9'b000001000,
        S_SH_WR = 9'b000010000,
        S_DONE = 9'b000100000,
        S_P_RD = 9'b001000000,
        S_P_CHK = 9'b010000000,
        S_OUT = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg [3];
    logic [CW-1:0] cnt_next [3];
    logic [7:0] starve_reg;
    logic [2:0] op_reg;
    logic [PID_BITS-1:0] pid_in_reg;
    logic [7:0] code_in_reg;
    logic [1:0] tb_reg, tb_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] sh_reg, sh_next;
    logic pass2_reg, pass2_next;
    logic [1:0] st_reg, st_next;
    logic [PID_BITS-1:0] opid_reg, opid_next;
    logic oh_reg, oh_next, oc_reg, oc_next;
    logic [7:0] ocode_reg, ocode_next;
    logic [DW-1:0] hold_reg, hold_next;

    logic we;
    logic [AW-1:0] waddr, raddr;
    logic [DW-1:0] wdata, rdata;
    logic [PID_BITS-1:0] r_pid, pid_w;
    logic [7:0] r_aux, age_inc;

    tlrq_ram #(.WIDTH(DW), .DEPTH(3 << IW)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    assign r_pid = rdata[DW-1:8];
    assign r_aux = rdata[7:0];
    assign pid_w = pid_in_reg;
    assign age_inc = (r_aux == AGE_MAX) ? r_aux : r_aux + 8'd1;

    function automatic logic [AW-1:0] addr(input logic [1:0] t, input logic [CW-1:0] i);
        return {t, i[IW-1:0]};
    endfunction

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            starve_reg <= STARVING_AGE_RESET;
        end
        else if (cfg_we)
        begin
            starve_reg <= cfg_wdata;
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        tb_next = tb_reg;
        idx_next = idx_reg;
        sh_next = sh_reg;
        pass2_next = pass2_reg;
        st_next = st_reg;
        opid_next = opid_reg;
        oh_next = oh_reg;
        oc_next = oc_reg;
        ocode_next = ocode_reg;
        hold_next = hold_reg;
        we = 1'b0;
        waddr = '0;
        wdata = '0;
        raddr = addr(tb_reg, idx_reg);
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    st_next = ST_OK;
                    opid_next = '0;
                    oh_next = 1'b0;
                    oc_next = 1'b0;
                    ocode_next = '0;
                    idx_next = '0;
                    pass2_next = 1'b0;
                    state_next = S_OUT;
                    case (opcode)
                        OP_ENQUEUE:
                        begin
                            if (is_high || crit_flag)
                            begin
                                if (cnt_reg[TB_HIGH] == FULLC)
                                begin
                                    st_next = ST_FULL;
                                end
                                else
                                begin
                                    we = 1'b1;
                                    waddr = addr(TB_HIGH, cnt_reg[TB_HIGH]);
                                    wdata = {pid, 6'd0, crit_flag, 1'b1};
                                    cnt_next[TB_HIGH] = cnt_reg[TB_HIGH] + 1'b1;
                                end
                            end
                            else if (cnt_reg[TB_NORMAL] == FULLC)
                            begin
                                st_next = ST_FULL;
                            end
                            else
                            begin
                                we = 1'b1;
                                waddr = addr(TB_NORMAL, cnt_reg[TB_NORMAL]);
                                wdata = {pid, 8'd0};
                                cnt_next[TB_NORMAL] = cnt_reg[TB_NORMAL] + 1'b1;
                            end
                        end
                        OP_EXITED:
                        begin
                            if (cnt_reg[TB_DEFUNCT] == FULLC)
                            begin
                                st_next = ST_FULL;
                            end
                            else
                            begin
                                we = 1'b1;
                                waddr = addr(TB_DEFUNCT, cnt_reg[TB_DEFUNCT]);
                                wdata = {pid, term_code};
                                cnt_next[TB_DEFUNCT] = cnt_reg[TB_DEFUNCT] + 1'b1;
                            end
                        end
                        OP_SELECT:
                        begin
                            if (cnt_reg[TB_HIGH] != '0)
                            begin
                                tb_next = TB_HIGH;
                                state_next = S_RD;
                            end
                            else if (cnt_reg[TB_NORMAL] != '0)
                            begin
                                tb_next = TB_NORMAL;
                                state_next = S_RD;
                            end
                            else
                            begin
                                st_next = ST_EMPTY;
                            end
                        end
                        OP_KILL:
                        begin
                            tb_next = TB_HIGH;
                            state_next = S_RD;
                        end
                        OP_REAP:
                        begin
                            tb_next = TB_DEFUNCT;
                            state_next = S_RD;
                        end
                        OP_PROMOTE:
                        begin
                            tb_next = TB_NORMAL;
                            state_next = S_RD;
                        end
                        default:
                        begin
                            state_next = S_OUT;
                        end
                    endcase
                end
            end
            // Issue a read of entry idx; past the count, end, restart or switch the scan.
            S_RD:
            begin
                if (idx_reg >= cnt_reg[tb_reg])
                begin
                    if (op_reg == OP_SELECT)
                    begin
                        // No critical entry: take the high head.
                        idx_next = '0;
                        pass2_next = 1'b1;
                        state_next = S_CHK;
                        raddr = addr(tb_reg, '0);
                    end
                    else if (op_reg == OP_KILL && tb_reg == TB_HIGH)
                    begin
                        tb_next = TB_NORMAL;
                        idx_next = '0;
                    end
                    else if (op_reg == OP_PROMOTE)
                    begin
                        state_next = S_OUT;
                    end
                    else
                    begin
                        st_next = ST_EMPTY;
                        state_next = S_OUT;
                    end
                end
                else
                begin
                    state_next = (op_reg == OP_PROMOTE) ? S_P_CHK : S_CHK;
                end
            end
            // Examine the word read for this entry.
            S_CHK:
            begin
                if (op_reg == OP_SELECT)
                begin
                    if (tb_reg == TB_NORMAL || pass2_reg || r_aux[1])
                    begin
                        opid_next = r_pid;
                        oh_next = (tb_reg == TB_HIGH) & r_aux[0];
                        oc_next = (tb_reg == TB_HIGH) & r_aux[1];
                        sh_next = idx_reg;
                        state_next = S_SH_RD;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                        state_next = S_RD;
                    end
                end
                else if (op_reg == OP_REAP && pid_in_reg == '0)
                begin
                    ocode_next = r_aux;
                    sh_next = '0;
                    state_next = S_SH_RD;
                end
                else if (r_pid == pid_w)
                begin
                    if (op_reg == OP_KILL && cnt_reg[TB_DEFUNCT] == FULLC)
                    begin
                        st_next = ST_FULL;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        ocode_next = (op_reg == OP_REAP) ? r_aux : 8'd0;
                        sh_next = idx_reg;
                        state_next = S_SH_RD;
                    end
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    state_next = S_RD;
                end
            end
            // Close the gap at sh: read sh+1, then write it to sh.
            S_SH_RD:
            begin
                if (sh_reg + 1'b1 >= cnt_reg[tb_reg])
                begin
                    cnt_next[tb_reg] = cnt_reg[tb_reg] - 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    raddr = addr(tb_reg, sh_reg + 1'b1);
                    state_next = S_SH_WR;
                end
            end
            S_SH_WR:
            begin
                we = 1'b1;
                waddr = addr(tb_reg, sh_reg);
                wdata = rdata;
                sh_next = sh_reg + 1'b1;
                state_next = S_SH_RD;
            end
            // After removal: kill adds a defunct entry; promote moves to high.
            S_DONE:
            begin
                if (op_reg == OP_KILL)
                begin
                    we = 1'b1;
                    waddr = addr(TB_DEFUNCT, cnt_reg[TB_DEFUNCT]);
                    wdata = {pid_w, code_in_reg};
                    cnt_next[TB_DEFUNCT] = cnt_reg[TB_DEFUNCT] + 1'b1;
                    state_next = S_OUT;
                end
                else if (op_reg == OP_PROMOTE)
                begin
                    we = 1'b1;
                    waddr = addr(TB_HIGH, cnt_reg[TB_HIGH]);
                    wdata = {hold_reg[DW-1:8], 8'd0};
                    cnt_next[TB_HIGH] = cnt_reg[TB_HIGH] + 1'b1;
                    state_next = S_RD;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            // Promote: age the entry, then move it or write it back.
            S_P_CHK:
            begin
                if (age_inc >= starve_reg && cnt_reg[TB_HIGH] != FULLC)
                begin
                    hold_next = {r_pid, age_inc};
                    sh_next = idx_reg;
                    state_next = S_SH_RD;
                end
                else
                begin
                    if (age_inc >= starve_reg)
                    begin
                        st_next = ST_FULL;
                    end
                    we = 1'b1;
                    waddr = addr(TB_NORMAL, idx_reg);
                    wdata = {r_pid, age_inc};
                    idx_next = idx_reg + 1'b1;
                    state_next = S_RD;
                end
            end
            S_OUT:
            begin
                if (!out_valid || out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg[0] <= '0;
            cnt_reg[1] <= '0;
            cnt_reg[2] <= '0;
            out_valid <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            if (state_reg == S_OUT && (!out_valid || out_ready))
            begin
                out_valid <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid <= 1'b0;
            end
        end
    end

    // Working and result payload registers.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            op_reg <= opcode;
            pid_in_reg <= pid;
            code_in_reg <= term_code;
        end
        tb_reg <= tb_next;
        idx_reg <= idx_next;
        sh_reg <= sh_next;
        pass2_reg <= pass2_next;
        st_reg <= st_next;
        opid_reg <= opid_next;
        oh_reg <= oh_next;
        oc_reg <= oc_next;
        ocode_reg <= ocode_next;
        hold_reg <= hold_next;
        if (state_reg == S_OUT && (!out_valid || out_ready))
        begin
            status <= st_reg;
            out_pid <= opid_reg;
            out_high <= oh_reg;
            out_critical <= oc_reg;
            out_term_code <= ocode_reg;
            high_count <= cnt_reg[TB_HIGH];
            normal_count <= cnt_reg[TB_NORMAL];
            defunct_count <= cnt_reg[TB_DEFUNCT];
        end
    end

    assign in_ready = (state_reg == S_IDLE);
endmodule
`default_nettype wire
